// ----- design/min_unique_element_select_defines.svh -----
// Assertion macros for the minimum unique element selector.
// Included by the top-level RTL file, which carries concurrent checks; uses its clk and arst_n.
`ifndef MIN_UNIQUE_ELEMENT_SELECT_DEFINES_SVH
`define MIN_UNIQUE_ELEMENT_SELECT_DEFINES_SVH
`ifndef SYNTHESIS
// Check that is switched off while reset is asserted.
`define MUES_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that also holds across reset.
`define MUES_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MUES_ASSERT(lbl, prop, msg)
`define MUES_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- design/mues_pkg.sv -----
// Shared types and constants for the minimum unique element selector.
// No dependencies; imported by mues_mem, mues_seq and the top level.
`default_nettype none
package mues_pkg;

	localparam int DATA_W        = 32;
	localparam int IDX_OUT_W     = 7;
	localparam int MAX_ITEMS_DEF = 128;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FETCH,
		ST_INNER,
		ST_DRAIN,
		ST_FINISH
	} mues_state_t;

	// Strobes from the sequencer to the datapath, one per phase of the scan.
	typedef struct packed {
		logic load;
		logic fetch;
		logic inner;
		logic drain;
		logic finish;
	} mues_ctl_t;

endpackage
`default_nettype wire

// ----- design/min_unique_element_select.sv -----
// Top level of the minimum unique element selector: load counter, scan datapath, result register.
// Depends on mues_pkg, mues_mem, mues_seq and min_unique_element_select_defines.svh.
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------------------------------------
//   input   | in_valid, in_stall | value, is_last
//   output  | out_valid,out_stall| min_value, min_index, unique_found, overflowed
//
// Elements are taken one per cycle while the block is loading a set.
// After the transaction marked is_last, the n stored elements are scanned before
// the result is registered; every element is compared against every other one
// through the second read port of the element store.
// in_stall stays high from the last transaction until the result has been loaded
// into the output register; a stalled result holds the block in its final step.
// arst_n clears the sequencer, the load count, the overflow flag and out_valid;
// the element store itself is not cleared, since only loaded entries are read.
`default_nettype none
`include "min_unique_element_select_defines.svh"
module min_unique_element_select #(
	parameter int MAX_ITEMS = mues_pkg::MAX_ITEMS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [mues_pkg::DATA_W-1:0]    value,
	input  wire logic                                  is_last,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed      [mues_pkg::DATA_W-1:0]    min_value,
	output logic             [mues_pkg::IDX_OUT_W-1:0] min_index,
	output logic                                       unique_found,
	output logic                                       overflowed
);
	import mues_pkg::*;

	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	mues_ctl_t         ctl;
	logic [IDX_W-1:0]  i_q, j_q, last_idx;
	logic [CNT_W-1:0]  load_count_q;
	logic              ovf_q;
	logic              in_take, start, room, out_free;
	logic [DATA_W-1:0] rd_a, rd_b;

	// Compare pipeline: one inner comparison per cycle, on the registered read data.
	logic              cmp_v_s1;
	logic [IDX_W-1:0]  cmp_j_s1;
	logic              hit, dup_q, dup_now;

	// Running selections: smallest unique value, and fallback minimum at its last index.
	logic              have_q;
	logic [DATA_W-1:0] best_val_q, fb_val_q;
	logic [IDX_W-1:0]  best_idx_q, fb_idx_q;
	logic              uniq_upd, fb_upd;

	// Result register.
	logic              out_valid_q;
	logic [DATA_W-1:0] res_val_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic              res_uniq_q, res_ovf_q;

	assign in_stall = !ctl.load;
	assign in_take  = in_valid && !in_stall;
	assign start    = in_take && is_last;
	assign room     = load_count_q < CNT_W'(MAX_ITEMS);
	assign last_idx = IDX_W'(load_count_q - CNT_W'(1));
	assign out_free = !out_valid_q || !out_stall;

	mues_mem #(
		.DEPTH (MAX_ITEMS),
		.AW    (IDX_W)
	) u_mem (
		.clk     (clk),
		.we      (in_take && room),
		.waddr   (load_count_q[IDX_W-1:0]),
		.wdata   (value),
		.re_a    (ctl.fetch),
		.raddr_a (i_q),
		.rdata_a (rd_a),
		.re_b    (ctl.inner),
		.raddr_b (j_q),
		.rdata_b (rd_b)
	);

	mues_seq #(
		.IDX_W (IDX_W)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.last_idx (last_idx),
		.out_free (out_free),
		.ctl      (ctl),
		.i_q      (i_q),
		.j_q      (j_q)
	);

	// Load counter and overflow flag. Both return to zero once the result is registered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
			ovf_q        <= 1'b0;
		end else if (ctl.finish && out_free) begin
			load_count_q <= '0;
			ovf_q        <= 1'b0;
		end else if (in_take) begin
			if (room) begin
				load_count_q <= load_count_q + CNT_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// An element equal to element i at another position marks i as duplicated.
	assign hit     = cmp_v_s1 && (cmp_j_s1 != i_q) && (rd_b == rd_a);
	assign dup_now = dup_q || hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_v_s1 <= 1'b0;
			dup_q    <= 1'b0;
			have_q   <= 1'b0;
		end else begin
			cmp_v_s1 <= ctl.inner;
			if (ctl.fetch) begin
				dup_q <= 1'b0;
			end else if (hit) begin
				dup_q <= 1'b1;
			end
			if (start) begin
				have_q <= 1'b0;
			end else if (uniq_upd) begin
				have_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_j_s1 <= j_q;
	end

	// When the inner pass over element i is complete, fold it into both selections.
	// The fallback uses <= so that ties move to the later position.
	assign uniq_upd = ctl.drain && !dup_now &&
		(!have_q || ($signed(rd_a) < $signed(best_val_q)));
	assign fb_upd   = ctl.drain &&
		((i_q == '0) || ($signed(rd_a) <= $signed(fb_val_q)));

	always_ff @(posedge clk) begin
		if (uniq_upd) begin
			best_val_q <= rd_a;
			best_idx_q <= i_q;
		end
		if (fb_upd) begin
			fb_val_q <= rd_a;
			fb_idx_q <= i_q;
		end
	end

	// Output register: loaded in the final step, held until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish && out_free) begin
			res_val_q  <= have_q ? best_val_q : fb_val_q;
			res_idx_q  <= have_q ? best_idx_q : fb_idx_q;
			res_uniq_q <= have_q;
			res_ovf_q  <= ovf_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign min_value    = res_val_q;
	assign unique_found = res_uniq_q;
	assign overflowed   = res_ovf_q;

	// Positions are reported modulo 128.
	generate
		if (IDX_W >= IDX_OUT_W) begin : g_idx_trunc
			assign min_index = res_idx_q[IDX_OUT_W-1:0];
		end else begin : g_idx_ext
			assign min_index = {{(IDX_OUT_W - IDX_W){1'b0}}, res_idx_q};
		end
	endgenerate

	`MUES_ASSERT(a_count_bound, load_count_q <= CNT_W'(MAX_ITEMS), "load count beyond capacity")
	`MUES_ASSERT(a_drain_last_j, ctl.drain |-> (cmp_v_s1 && (cmp_j_s1 == last_idx)), "drain without final compare")
	`MUES_ASSERT(a_result_source, $rose(out_valid_q) |-> $past(ctl.finish), "result outside final step")
	`MUES_ASSERT(a_scan_nonempty, ctl.fetch |-> (load_count_q != '0), "scan of an empty set")
	`MUES_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid_q, "result valid during reset")

endmodule
`default_nettype wire

// ----- design/mues_mem.sv -----
// Element store: one write port, two read ports with registered read data.
// Depends on mues_pkg for the data width.
`default_nettype none
module mues_mem #(
	parameter int DEPTH = mues_pkg::MAX_ITEMS_DEF,
	parameter int AW    = $clog2(mues_pkg::MAX_ITEMS_DEF)
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [mues_pkg::DATA_W-1:0] wdata,
	input  wire logic                        re_a,
	input  wire logic [AW-1:0]               raddr_a,
	output logic      [mues_pkg::DATA_W-1:0] rdata_a,
	input  wire logic                        re_b,
	input  wire logic [AW-1:0]               raddr_b,
	output logic      [mues_pkg::DATA_W-1:0] rdata_b
);
	import mues_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re_a) begin
			rdata_a <= mem_q[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule
`default_nettype wire

// ----- design/mues_seq.sv -----
// Scan sequencer: walks the outer index i and inner index j over the loaded set.
// Depends on mues_pkg for the state and control types.
`default_nettype none
module mues_seq #(
	parameter int IDX_W = $clog2(mues_pkg::MAX_ITEMS_DEF)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [IDX_W-1:0]    last_idx,
	input  wire logic                out_free,
	output mues_pkg::mues_ctl_t      ctl,
	output logic      [IDX_W-1:0]    i_q,
	output logic      [IDX_W-1:0]    j_q
);
	import mues_pkg::*;

	mues_state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:   if (start) state_d = ST_FETCH;
			ST_FETCH:  state_d = ST_INNER;
			ST_INNER:  if (j_q == last_idx) state_d = ST_DRAIN;
			ST_DRAIN:  state_d = (i_q == last_idx) ? ST_FINISH : ST_FETCH;
			ST_FINISH: if (out_free) state_d = ST_LOAD;
			default:   state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_LOAD:   ctl.load   = 1'b1;
			ST_FETCH:  ctl.fetch  = 1'b1;
			ST_INNER:  ctl.inner  = 1'b1;
			ST_DRAIN:  ctl.drain  = 1'b1;
			ST_FINISH: ctl.finish = 1'b1;
			default:   ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.load && start) begin
				i_q <= '0;
			end else if (ctl.drain) begin
				i_q <= i_q + 1'b1;
			end
			if (ctl.fetch) begin
				j_q <= '0;
			end else if (ctl.inner) begin
				j_q <= j_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire
